@@ hw/rtl/rqmin_pkg.sv @@
`timescale 1ns / 1ps

package rqmin_pkg;

  // queue geometry
  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int unsigned ID_W  = 10;
  localparam int unsigned PRI_W = 8;
  localparam int unsigned OCC_W = 6;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2,
    OP_EXTRACT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // circular pointer step forward
  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] ptr);
    logic [IDX_W-1:0] nxt;
    if (ptr == IDX_W'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

  // circular pointer step back
  function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] ptr);
    logic [IDX_W-1:0] nxt;
    if (ptr == '0) begin
      nxt = IDX_W'(QUEUE_DEPTH - 1);
    end else begin
      nxt = ptr - 1'b1;
    end
    return nxt;
  endfunction

endpackage

@@ hw/rtl/ready_queue_with_min_priority_extract_top.sv @@
`timescale 1ns / 1ps
// Sequencing: enqueue, or any operation on an empty queue, goes from idle straight to the done
// state; dequeue and peek pass through a head state that takes the memory read. Extract
// scans the held entries, reading one entry per cycle from the entry memory, then compaction
// moves one entry per cycle through its single read port and single write port.
// Throughput: one transaction at a time; the next is accepted once the result is registered.
// Reset: asynchronous, active low; the queue comes up empty, memory contents are not cleared.
module ready_queue_with_min_priority_extract_top
  import rqmin_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       operation_i,
  input  logic [ID_W-1:0]  proc_id_i,
  input  logic [PRI_W-1:0] proc_priority_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ID_W-1:0]  out_id_o,
  output logic [PRI_W-1:0] out_priority_o,
  output logic [1:0]       status_o,
  output logic [OCC_W-1:0] occupancy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_e;

  state_e            state_q;
  op_e               op_q;
  logic [IDX_W-1:0]  head_q;
  logic [IDX_W-1:0]  tail_q;
  logic [CNT_W-1:0]  count_q;

  // scan / compaction bookkeeping
  logic [IDX_W-1:0]  scan_ptr_q;
  logic [CNT_W-1:0]  scan_left_q;
  logic [IDX_W-1:0]  dst_ptr_q;
  logic              rd_v_q;
  logic [IDX_W-1:0]  rd_ptr_q;
  logic              first_q;
  entry_t            best_q;
  logic [IDX_W-1:0]  best_ptr_q;
  logic              mv_v_q;
  logic [IDX_W-1:0]  mv_dst_q;

  // pending result and output register
  entry_t            res_q;
  status_e           res_status_q;
  logic              out_valid_q;
  entry_t            out_q;
  status_e           out_status_q;
  logic [OCC_W-1:0]  out_occ_q;

  // entry memory
  entry_t            mem_q [QUEUE_DEPTH];
  entry_t            rd_data_q;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;

  logic              in_fire;
  op_e               in_op;
  logic              is_full;
  logic              is_empty;
  logic              out_free;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_op      = op_e'(operation_i);
  assign is_full    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign is_empty   = (count_q == '0);
  assign out_free   = !out_valid_q || out_ready_i;
  assign occ_ext    = {{OCC_W{1'b0}}, count_q};

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = head_q;
    mem_we    = 1'b0;
    mem_waddr = tail_q;
    mem_wdata = '{id: proc_id_i, pri: proc_priority_i};
    unique case (state_q)
      ST_IDLE: begin
        mem_re = in_fire && (in_op != OP_ENQUEUE);
        mem_we = in_fire && (in_op == OP_ENQUEUE) && !is_full;
      end
      ST_SCAN: begin
        mem_re    = (scan_left_q != '0);
        mem_raddr = scan_ptr_q;
      end
      ST_SHIFT: begin
        mem_re    = (scan_ptr_q != tail_q);
        mem_raddr = scan_ptr_q;
        mem_we    = mv_v_q;
        mem_waddr = mv_dst_q;
        mem_wdata = rd_data_q;
      end
      ST_HEAD, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // synchronous memory, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_ENQUEUE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      scan_ptr_q   <= '0;
      scan_left_q  <= '0;
      dst_ptr_q    <= '0;
      rd_v_q       <= 1'b0;
      rd_ptr_q     <= '0;
      first_q      <= 1'b0;
      best_q       <= '0;
      best_ptr_q   <= '0;
      mv_v_q       <= 1'b0;
      mv_dst_q     <= '0;
      res_q        <= '0;
      res_status_q <= STATUS_OK;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      out_status_q <= STATUS_OK;
      out_occ_q    <= '0;
    end else begin
      // output transaction taken
      if (out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            op_q  <= in_op;
            res_q <= '0;
            if (in_op == OP_ENQUEUE) begin
              if (is_full) begin
                res_status_q <= STATUS_FULL;
              end else begin
                res_status_q <= STATUS_OK;
                tail_q       <= ptr_inc(tail_q);
                count_q      <= count_q + 1'b1;
              end
              state_q <= ST_DONE;
            end else if (is_empty) begin
              res_status_q <= STATUS_EMPTY;
              state_q      <= ST_DONE;
            end else if (in_op == OP_EXTRACT) begin
              scan_ptr_q  <= head_q;
              scan_left_q <= count_q;
              rd_v_q      <= 1'b0;
              first_q     <= 1'b1;
              state_q     <= ST_SCAN;
            end else begin
              state_q <= ST_HEAD;
            end
          end
        end

        // head entry is in the read register
        ST_HEAD: begin
          res_q        <= rd_data_q;
          res_status_q <= STATUS_OK;
          if (op_q == OP_DEQUEUE) begin
            head_q  <= ptr_inc(head_q);
            count_q <= count_q - 1'b1;
          end
          state_q <= ST_DONE;
        end

        // read every held entry, keep the earliest strict minimum
        ST_SCAN: begin
          if (scan_left_q != '0) begin
            scan_ptr_q  <= ptr_inc(scan_ptr_q);
            scan_left_q <= scan_left_q - 1'b1;
          end
          rd_v_q   <= (scan_left_q != '0);
          rd_ptr_q <= scan_ptr_q;
          if (rd_v_q) begin
            if (first_q || (rd_data_q.pri < best_q.pri)) begin
              best_q     <= rd_data_q;
              best_ptr_q <= rd_ptr_q;
            end
            first_q <= 1'b0;
          end
          if ((scan_left_q == '0) && !rd_v_q) begin
            scan_ptr_q <= ptr_inc(best_ptr_q);
            dst_ptr_q  <= best_ptr_q;
            mv_v_q     <= 1'b0;
            state_q    <= ST_SHIFT;
          end
        end

        // move entries behind the minimum up one slot
        ST_SHIFT: begin
          if (scan_ptr_q != tail_q) begin
            mv_v_q     <= 1'b1;
            mv_dst_q   <= dst_ptr_q;
            dst_ptr_q  <= scan_ptr_q;
            scan_ptr_q <= ptr_inc(scan_ptr_q);
          end else begin
            mv_v_q <= 1'b0;
            if (!mv_v_q) begin
              tail_q       <= ptr_dec(tail_q);
              count_q      <= count_q - 1'b1;
              res_q        <= best_q;
              res_status_q <= STATUS_OK;
              state_q      <= ST_DONE;
            end
          end
        end

        // hand the result to the output register
        ST_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_q        <= res_q;
            out_status_q <= res_status_q;
            out_occ_q    <= occ_ext[OCC_W-1:0];
            state_q      <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_id_o       = out_q.id;
  assign out_priority_o = out_q.pri;
  assign status_o       = out_status_q;
  assign occupancy_o    = out_occ_q;

  // expected tail from head and count, for checking
  logic [CNT_W:0]   tail_sum;
  logic [IDX_W-1:0] tail_exp;
  assign tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
  assign tail_exp = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                    IDX_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

  // count never exceeds the store
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");

  // pointers agree with count between transactions
  a_tail_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (tail_q == tail_exp))
    else $error("tail pointer out of step with head and count");

  // compaction writes only during compaction
  a_move_in_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_v_q |-> (state_q == ST_SHIFT))
    else $error("entry move outside compaction");

  // accepted enqueue into a non-full queue grows the count by one
  a_enqueue_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_op == OP_ENQUEUE) && !is_full) |=>
      (count_q == $past(count_q) + 1'b1))
    else $error("enqueue did not grow the count");

endmodule
